// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the particle pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PPS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("particle pool assertion failed");

// Next-cycle implication, disabled during reset.
`define PPS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("particle pool assertion failed");

`endif

// ===== rtl/core/pps_pkg.sv =====
// Types and constants of the particle pool motion step block.
package pps_pkg;

   localparam int SLOTS  = 12;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // divider geometry: 15-bit dividend, 8-bit divisor
   localparam int DIVD_W = 15;
   localparam int DIVS_W = 8;
   localparam int DCNT_W = $clog2(DIVD_W + 1);

   localparam logic [7:0] STEP_ONE_FRAME = 8'hFF;

   typedef enum logic [1:0] {
      MODE_EMIT  = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [14:0]       rand_x;
      logic [14:0]       rand_y;
      logic [6:0]        spread;
      logic signed [7:0] lift;
      logic [7:0]        lifetime;
      logic signed [7:0] gravity_step;
      logic [7:0]        frame_count;
      logic [7:0]        sprite_id;
      logic              burst_end;
   } req_type;

   typedef struct packed {
      logic [7:0]         draw_sprite;
      logic [7:0]         draw_frame;
      logic signed [11:0] world_x;
      logic signed [11:0] world_y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [15:0] vel_x;
      logic [15:0] vel_y;
      logic [7:0]  age;
      logic [7:0]  frame;
      logic [7:0]  timer;
      logic [7:0]  step;
      logic [7:0]  lifetime;
      logic [7:0]  gravity;
      logic [7:0]  frames;
      logic [7:0]  sprite;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMIT_DIV,
      ST_TICK_RD,
      ST_TICK_UPD,
      ST_TICK_FLUSH
   } state_type;

endpackage

// ===== rtl/core/pps_ram.sv =====
// Generic single-port-write, registered-read RAM.
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/pps_div.sv =====
// Restoring divider, one quotient bit per cycle.
module pps_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pps_pkg::DIVD_W-1:0]  dividend,
   input  logic [pps_pkg::DIVS_W-1:0]  divisor,
   output logic                        busy,
   output logic [pps_pkg::DIVD_W-1:0]  quotient,
   output logic [pps_pkg::DIVS_W-1:0]  remainder
);

   logic                        busy_ff, busy_in;
   logic [pps_pkg::DCNT_W-1:0]  cnt_ff, cnt_in;
   logic [pps_pkg::DIVD_W-1:0]  dvd_ff, dvd_in;
   logic [pps_pkg::DIVS_W-1:0]  dvs_ff, dvs_in;
   logic [pps_pkg::DIVS_W-1:0]  rem_ff, rem_in;
   logic [pps_pkg::DIVS_W:0]    rem_sh;
   logic [pps_pkg::DIVS_W:0]    rem_diff;

   // shift in the next dividend bit and trial-subtract
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      dvs_in   = dvs_ff;
      rem_in   = rem_ff;
      rem_sh   = {rem_ff, dvd_ff[pps_pkg::DIVD_W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_diff[pps_pkg::DIVS_W-1:0];
            dvd_in = {dvd_ff[pps_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[pps_pkg::DIVS_W-1:0];
            dvd_in = {dvd_ff[pps_pkg::DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == pps_pkg::DCNT_W'(pps_pkg::DIVD_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign quotient  = dvd_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/particle_pool_motion_step.sv =====
// Top level of the particle pool: sequencer, slot memory and dividers.
//
// Use: one request channel (req_valid/req_ready/req_data) carries emit,
// tick and clear commands; the response channel (rsp_valid/rsp_ready/
// rsp_data) carries draw words, produced by ticks only.
// Emit: writes the slot at the round-robin pointer. Three restoring
// dividers run side by side (two velocity moduli and the frame step), and
// the next request is taken once they finish and the slot is written.
// Clear: frees every slot and rewinds the pointer.
// Tick: walks the slots in ascending order through the slot memory; a free
// slot is skipped, a live one is read, then updated and written back or
// retired, and a flush step ends the walk. Each draw word is held back
// until the next one so that the final one can carry last. An output
// register lets the sequencer run on while a word waits; a stalled receiver
// holds the walk only when that register is full and a word is held back.
// Reset: synchronous, clears live flags, pointer and control; slot memory
// contents are not cleared and need no clearing pass.
module particle_pool_motion_step (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  pps_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output pps_pkg::rsp_type rsp_data
);

`include "assert_macros.svh"

   pps_pkg::state_type         state_ff, state_in;
   logic [pps_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [pps_pkg::SLOT_W-1:0] wp_ff, wp_in;
   logic [pps_pkg::SLOTS-1:0]  live_ff, live_in;
   pps_pkg::req_type           em_ff, em_in;
   logic                       pend_valid_ff, pend_valid_in;
   pps_pkg::rsp_type           pend_ff, pend_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   pps_pkg::rsp_type           rsp_ff, rsp_in;

   logic                       ram_we, ram_re;
   logic [pps_pkg::SLOT_W-1:0] ram_waddr;
   pps_pkg::slot_type          ram_wdata, ram_rdata;
   logic [pps_pkg::SLOT_BITS-1:0] ram_rbits;

   logic                       div_start;
   logic                       busy_x, busy_y, busy_s;
   logic [pps_pkg::DIVD_W-1:0] quot_x, quot_y, quot_s;
   logic [pps_pkg::DIVS_W-1:0] rem_x, rem_y, rem_s;
   logic [pps_pkg::DIVS_W-1:0] modulus;

   logic        out_free, idx_end;
   logic [7:0]  vx8, vy8, step8;
   logic [15:0] vel_x, vel_y;
   pps_pkg::slot_type new_slot, upd_slot;
   logic [7:0]  age1, timer1;
   logic        retire;
   pps_pkg::rsp_type draw;

   // slot memory
   pps_ram #(
      .WIDTH (pps_pkg::SLOT_BITS),
      .DEPTH (pps_pkg::SLOTS)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (idx_ff),
      .rdata (ram_rbits)
   );
   assign ram_rdata = pps_pkg::slot_type'(ram_rbits);

   // velocity moduli and frame step dividers
   assign modulus = {em_in.spread, 1'b1};

   pps_div u_div_x (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (em_in.rand_x), .divisor (modulus),
      .busy (busy_x), .quotient (quot_x), .remainder (rem_x)
   );
   pps_div u_div_y (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (em_in.rand_y), .divisor (modulus),
      .busy (busy_y), .quotient (quot_y), .remainder (rem_y)
   );
   pps_div u_div_s (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend ({{(pps_pkg::DIVD_W-8){1'b0}}, em_in.lifetime}),
      .divisor (em_in.frame_count),
      .busy (busy_s), .quotient (quot_s), .remainder (rem_s)
   );

   // build the emitted slot from divider results
   always_comb begin
      vx8 = rem_x - {1'b0, em_ff.spread};
      vy8 = rem_y - {1'b0, em_ff.spread};
      if (em_ff.spread == '0) begin
         vx8 = '0;
         vy8 = '0;
      end
      vel_x = {{8{vx8[7]}}, vx8};
      vel_y = {{8{vy8[7]}}, vy8} + {{8{em_ff.lift[7]}}, em_ff.lift};
      step8 = (em_ff.frame_count > 8'd1) ? quot_s[7:0] : pps_pkg::STEP_ONE_FRAME;
      if (step8 == '0) begin
         step8 = 8'd1;
      end
      new_slot.pos_x    = {em_ff.pos_x, 4'b0};
      new_slot.pos_y    = {em_ff.pos_y, 4'b0};
      new_slot.vel_x    = vel_x;
      new_slot.vel_y    = vel_y;
      new_slot.age      = '0;
      new_slot.frame    = '0;
      new_slot.timer    = '0;
      new_slot.step     = step8;
      new_slot.lifetime = em_ff.lifetime;
      new_slot.gravity  = em_ff.gravity_step;
      new_slot.frames   = em_ff.frame_count;
      new_slot.sprite   = em_ff.sprite_id;
   end

   // age, move and animate the slot just read
   always_comb begin
      upd_slot  = ram_rdata;
      age1      = ram_rdata.age + 8'd1;
      retire    = (age1 >= ram_rdata.lifetime);
      timer1    = ram_rdata.timer + 8'd1;
      upd_slot.age   = age1;
      upd_slot.vel_y = ram_rdata.vel_y + {{8{ram_rdata.gravity[7]}}, ram_rdata.gravity};
      upd_slot.pos_x = ram_rdata.pos_x + ram_rdata.vel_x;
      upd_slot.pos_y = ram_rdata.pos_y + upd_slot.vel_y;
      upd_slot.timer = timer1;
      if (timer1 >= ram_rdata.step) begin
         upd_slot.timer = '0;
         if (({1'b0, ram_rdata.frame} + 9'd1) < {1'b0, ram_rdata.frames}) begin
            upd_slot.frame = ram_rdata.frame + 8'd1;
         end
      end
      draw.draw_sprite = ram_rdata.sprite;
      draw.draw_frame  = upd_slot.frame;
      draw.world_x     = upd_slot.pos_x[15:4];
      draw.world_y     = upd_slot.pos_y[15:4];
      draw.last        = 1'b0;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_end  = (idx_ff == pps_pkg::SLOT_W'(pps_pkg::SLOTS - 1));

   // sequencer: next state and datapath controls
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      wp_in         = wp_ff;
      live_in       = live_ff;
      em_in         = em_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      req_ready     = 1'b0;
      div_start     = 1'b0;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = idx_ff;
      ram_wdata     = upd_slot;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_data.mode)
                  pps_pkg::MODE_EMIT: begin
                     em_in     = req_data;
                     div_start = 1'b1;
                     state_in  = pps_pkg::ST_EMIT_DIV;
                  end
                  pps_pkg::MODE_TICK: begin
                     idx_in   = '0;
                     state_in = pps_pkg::ST_TICK_RD;
                  end
                  pps_pkg::MODE_CLEAR: begin
                     live_in = '0;
                     wp_in   = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pps_pkg::ST_EMIT_DIV: begin
            if (!busy_x && !busy_y && !busy_s) begin
               ram_we         = 1'b1;
               ram_waddr      = wp_ff;
               ram_wdata      = new_slot;
               live_in[wp_ff] = 1'b1;
               wp_in          = (wp_ff == pps_pkg::SLOT_W'(pps_pkg::SLOTS - 1)) ?
                                '0 : wp_ff + 1'b1;
               state_in       = pps_pkg::ST_IDLE;
            end
         end
         pps_pkg::ST_TICK_RD: begin
            if (live_ff[idx_ff]) begin
               ram_re   = 1'b1;
               state_in = pps_pkg::ST_TICK_UPD;
            end else if (idx_end) begin
               state_in = pps_pkg::ST_TICK_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         pps_pkg::ST_TICK_UPD: begin
            if (retire || !pend_valid_ff || out_free) begin
               if (retire) begin
                  live_in[idx_ff] = 1'b0;
               end else begin
                  ram_we = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = draw;
               end
               if (idx_end) begin
                  state_in = pps_pkg::ST_TICK_FLUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = pps_pkg::ST_TICK_RD;
               end
            end
         end
         pps_pkg::ST_TICK_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = pps_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = pps_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pps_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pps_pkg::ST_IDLE;
         idx_ff        <= '0;
         wp_ff         <= '0;
         live_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         wp_ff         <= wp_in;
         live_ff       <= live_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      em_ff   <= em_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a held-back draw word exists only inside a tick walk
   `PPS_ASSERT_IMP(a_pend_in_tick, clock, reset, pend_valid_ff,
      state_ff == pps_pkg::ST_TICK_RD || state_ff == pps_pkg::ST_TICK_UPD ||
      state_ff == pps_pkg::ST_TICK_FLUSH)
   // a clear leaves the pool empty with the pointer rewound
   `PPS_ASSERT_NXT(a_clear_empties, clock, reset,
      req_valid && req_ready && req_data.mode == pps_pkg::MODE_CLEAR,
      live_ff == '0 && wp_ff == '0)
   // an emit write marks its slot live
   `PPS_ASSERT_NXT(a_emit_live, clock, reset,
      state_ff == pps_pkg::ST_EMIT_DIV && ram_we, live_ff[$past(wp_ff)])

endmodule

// ===== verif/particle_pool_motion_step_test.sv =====
// Self-checking testbench for the particle pool motion step block.
`timescale 1ns / 100ps

module particle_pool_motion_step_test;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 245;

   typedef struct packed {
      logic        live;
      logic [15:0] px;
      logic [15:0] py;
      logic [15:0] vx;
      logic [15:0] vy;
      logic [7:0]  age;
      logic [7:0]  frame;
      logic [7:0]  timer;
      logic [7:0]  step;
      logic [7:0]  life;
      logic [7:0]  grav;
      logic [7:0]  frames;
      logic [7:0]  sprite;
   } pool_entry_type;

   // one directed row: typed_n < 0 means the draws come from the pool model
   typedef struct {
      pps_pkg::req_type r;
      int               typed_n;
      pps_pkg::rsp_type typed;
   } row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pps_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pps_pkg::rsp_type rsp_data;

   pool_entry_type   pool [pps_pkg::SLOTS];
   int               wr_slot;
   pps_pkg::rsp_type draw_queue [$];
   pps_pkg::rsp_type tick_draws [$];
   int               failures, words_in, draws_seen, ticks_sent, emits_sent;
   int               idle_cycles;
   bit               hold_request;
   row_type          rows [$];

   particle_pool_motion_step dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // velocity from a raw random value, centred on zero, 8-bit wrapped
   function automatic logic [15:0] spread_velocity(logic [14:0] r, logic [6:0] spread);
      logic [7:0] m;
      logic [7:0] q;
      logic [7:0] v;
      if (spread == 0) return 16'd0;
      m = {spread, 1'b1};
      q = 8'(r % m);
      v = q - {1'b0, spread};
      return {{8{v[7]}}, v};
   endfunction

   // update the pool copy for one word; ticks leave their draws in tick_draws
   task automatic advance_pool(input pps_pkg::req_type r);
      int s;
      logic [7:0] st;
      pps_pkg::rsp_type d;
      tick_draws.delete();
      case (pps_pkg::mode_type'(r.mode))
         pps_pkg::MODE_EMIT: begin
            s = wr_slot;
            wr_slot = (s + 1 >= pps_pkg::SLOTS) ? 0 : s + 1;
            pool[s].live  = 1'b1;
            pool[s].px    = {r.pos_x, 4'b0};
            pool[s].py    = {r.pos_y, 4'b0};
            pool[s].vx    = spread_velocity(r.rand_x, r.spread);
            pool[s].vy    = spread_velocity(r.rand_y, r.spread) + {{8{r.lift[7]}}, r.lift};
            pool[s].age   = 8'd0;
            pool[s].frame = 8'd0;
            pool[s].timer = 8'd0;
            st = (r.frame_count > 1) ? r.lifetime / r.frame_count
                                     : pps_pkg::STEP_ONE_FRAME;
            pool[s].step   = (st == 0) ? 8'd1 : st;
            pool[s].life   = r.lifetime;
            pool[s].grav   = r.gravity_step;
            pool[s].frames = r.frame_count;
            pool[s].sprite = r.sprite_id;
         end
         pps_pkg::MODE_TICK: begin
            for (int i = 0; i < pps_pkg::SLOTS; i++) begin
               if (!pool[i].live) continue;
               pool[i].age++;
               if (pool[i].age >= pool[i].life) begin
                  pool[i].live = 1'b0;
                  continue;
               end
               pool[i].vy += {{8{pool[i].grav[7]}}, pool[i].grav};
               pool[i].px += pool[i].vx;
               pool[i].py += pool[i].vy;
               pool[i].timer++;
               if (pool[i].timer >= pool[i].step) begin
                  pool[i].timer = 8'd0;
                  if (9'(pool[i].frame) + 9'd1 < 9'(pool[i].frames)) pool[i].frame++;
               end
               d.draw_sprite = pool[i].sprite;
               d.draw_frame  = pool[i].frame;
               d.world_x     = pool[i].px[15:4];
               d.world_y     = pool[i].py[15:4];
               d.last        = 1'b0;
               tick_draws.push_back(d);
            end
            if (tick_draws.size() > 0) tick_draws[tick_draws.size() - 1].last = 1'b1;
         end
         pps_pkg::MODE_CLEAR: begin
            for (int i = 0; i < pps_pkg::SLOTS; i++) pool[i].live = 1'b0;
            wr_slot = 0;
         end
         default: ;
      endcase
   endtask

   // offer one word and hold it until accepted, then record what it causes
   task automatic send(input pps_pkg::req_type r, input int typed_n,
                       input pps_pkg::rsp_type typed);
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_in++;
      if (r.mode == pps_pkg::MODE_TICK) ticks_sent++;
      if (r.mode == pps_pkg::MODE_EMIT) emits_sent++;
      advance_pool(r);
      if (typed_n >= 0) begin
         if (typed_n > 0) draw_queue.push_back(typed);
      end else begin
         foreach (tick_draws[k]) draw_queue.push_back(tick_draws[k]);
      end
   endtask

   task automatic pause(input int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic pps_pkg::req_type mk_emit(logic [11:0] px, logic [11:0] py,
         logic [14:0] rx, logic [14:0] ry, logic [6:0] spread, logic [7:0] lift,
         logic [7:0] life, logic [7:0] grav, logic [7:0] fc, logic [7:0] sprite, logic be);
      pps_pkg::req_type r;
      r = '{mode: pps_pkg::MODE_EMIT, pos_x: px, pos_y: py, rand_x: rx, rand_y: ry,
            spread: spread, lift: lift, lifetime: life, gravity_step: grav,
            frame_count: fc, sprite_id: sprite, burst_end: be};
      return r;
   endfunction

   function automatic pps_pkg::req_type mk_op(pps_pkg::mode_type m);
      pps_pkg::req_type r;
      r = '0;
      r.mode = m;
      return r;
   endfunction

   function automatic pps_pkg::req_type random_word(pps_pkg::mode_type m);
      pps_pkg::req_type r;
      r = mk_emit(12'($urandom), 12'($urandom), 15'($urandom), 15'($urandom),
                  7'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 1'($urandom));
      r.mode = m;
      return r;
   endfunction

   function automatic row_type row(pps_pkg::req_type r, int n = -1,
                                   pps_pkg::rsp_type t = '0);
      row_type w;
      w.r = r;
      w.typed_n = n;
      w.typed = t;
      return w;
   endfunction

   // check each draw word against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         draws_seen++;
         if (draw_queue.size() == 0) begin
            $error("unexpected draw word %h", rsp_data);
            failures++;
         end else begin
            pps_pkg::rsp_type e;
            e = draw_queue.pop_front();
            if (rsp_data.draw_sprite !== e.draw_sprite) begin
               $error("draw_sprite expected %0d got %0d", e.draw_sprite, rsp_data.draw_sprite);
               failures++;
            end
            if (rsp_data.draw_frame !== e.draw_frame) begin
               $error("draw_frame expected %0d got %0d", e.draw_frame, rsp_data.draw_frame);
               failures++;
            end
            if (rsp_data.world_x !== e.world_x) begin
               $error("world_x expected %0d got %0d", e.world_x, rsp_data.world_x);
               failures++;
            end
            if (rsp_data.world_y !== e.world_y) begin
               $error("world_y expected %0d got %0d", e.world_y, rsp_data.world_y);
               failures++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last expected %0d got %0d", e.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("particle_pool_motion_step verification failed");
         $finish;
      end
   end

   // receiver: random stalls, solid stretches, and one long hold-off
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            n = $urandom_range(0, 9);
            if (n == 0) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end else begin
               rsp_ready <= (n > 3);
               repeat ($urandom_range(0, 5)) @(posedge clock);
            end
         end
      end
   end

   // sender: directed table, then bursty random sequences
   initial begin
      pps_pkg::rsp_type t;
      pps_pkg::req_type r;
      int burst;
      failures = 0; words_in = 0; draws_seen = 0; ticks_sent = 0; emits_sent = 0;
      idle_cycles = 0; hold_request = 1'b0; wr_slot = 0;
      foreach (pool[i]) pool[i] = '0;

      // empty tick, unused mode, simple still particle, extremes, lifetime zero,
      // frame step forced to one, clear, then pointer wrap-around
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK), 0));
      rows.push_back(row(mk_op(pps_pkg::MODE_NONE), 0));
      rows.push_back(row(mk_emit(12'd100, -12'sd50, 15'd7, 15'd9, 7'd0, 8'd0, 8'd3,
                                 8'd0, 8'd1, 8'hAA, 1'b1)));
      t = '{draw_sprite: 8'hAA, draw_frame: 8'd0, world_x: 12'd100, world_y: -12'sd50,
            last: 1'b1};
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK), 1, t));
      rows.push_back(row(mk_emit(12'h7FF, 12'h800, 15'h7FFF, 15'h7FFF, 7'h7F, 8'h80,
                                 8'hFF, 8'h7F, 8'hFF, 8'hFF, 1'b0)));
      rows.push_back(row(mk_emit(12'h800, 12'h7FF, 15'h0, 15'h0, 7'h7F, 8'h7F, 8'h00,
                                 8'h80, 8'h00, 8'h00, 1'b1)));
      rows.push_back(row(mk_emit(12'h555, 12'hAAA, 15'h5555, 15'h2AAA, 7'h55, 8'h55,
                                 8'd1, 8'hAA, 8'd2, 8'h55, 1'b0)));
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK)));
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK)));
      rows.push_back(row(mk_op(pps_pkg::MODE_CLEAR), 0));
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK), 0));
      for (int i = 0; i < pps_pkg::SLOTS + 1; i++)
         rows.push_back(row(mk_emit(12'(i * 37 - 200), 12'(300 - i * 41), 15'(i * 911),
                                    15'(i * 577), 7'(i * 9), 8'(i * 19 - 100), 8'(20 + i),
                                    8'(i - 6), 8'(i), 8'(i), 1'(i == pps_pkg::SLOTS))));
      rows.push_back(row(mk_op(pps_pkg::MODE_TICK)));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         send(rows[i].r, rows[i].typed_n, rows[i].typed);
         if ($urandom_range(0, 2) == 0) pause($urandom_range(1, 6));
      end

      // random part: a random mix of emits, ticks, some clears and noise, in bursts
      burst = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case ($urandom_range(0, 19))
            0:          r = random_word(pps_pkg::MODE_CLEAR);
            1:          r = random_word(pps_pkg::MODE_NONE);
            2, 3, 4, 5, 6, 7, 8: r = random_word(pps_pkg::MODE_EMIT);
            default:    r = random_word(pps_pkg::MODE_TICK);
         endcase
         if (i == 100) hold_request = 1'b1;
         if (i == 180) begin
            pause(1);
            wait (draw_queue.size() == 0);
            @(posedge clock);
         end
         send(r, -1, '0);
         if (burst == 0) begin
            burst = $urandom_range(1, 10);
            if ($urandom_range(0, 1)) pause($urandom_range(1, 15));
         end else begin
            burst--;
         end
      end
      pause(1);

      wait (draw_queue.size() == 0);
      repeat (40) @(posedge clock);

      $display("run covered %0d words (%0d emits, %0d ticks) and %0d draw words",
               words_in, emits_sent, ticks_sent, draws_seen);
      if (failures == 0)
         $display("particle_pool_motion_step verification clean");
      else
         $display("particle_pool_motion_step verification failed");
      $finish;
   end

endmodule
